// ===== rtl/core/cssb_pkg.sv =====
// Shared types, request codes and constants for the byte sequence shift buffer.
`timescale 1ns / 1ps

package cssb_pkg;

    localparam int CSSB_DEPTH_DEF = 128;

    localparam int REQ_W = 3;
    localparam int IDX_W = 7;
    localparam int VAL_W = 8;
    localparam int LEN_W = 8;
    localparam int CNT_W = 8;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RUN    = 3'd4;

    // What the datapath decided to do with the captured request.
    typedef enum logic [2:0] {
        OP_REJECT,
        OP_APPEND,
        OP_SHIFT_IN,
        OP_DELETE,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHR_RD,
        S_SHR_WR,
        S_SHL_RD,
        S_SHL_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic wr_append;
        logic wr_shift;
        logic wr_put;
        logic rd_idx;
        logic rd_prev;
        logic rd_next;
        logic cur_dec;
        logic cur_inc;
        logic occ_inc;
        logic occ_dec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic cur_gt_tgt;
        logic cur_next_lt_occ;
    } t_sts;

endpackage

// ===== rtl/core/cssb_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps

module cssb_ctrl
    import cssb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.op == OP_SHIFT_IN) begin
                    n_state = S_SHR_RD;
                end else if (i_sts.op == OP_DELETE) begin
                    n_state = S_SHL_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SHR_RD: begin
                n_state = i_sts.cur_gt_tgt ? S_SHR_WR : S_RESP;
            end
            S_SHR_WR: n_state = S_SHR_RD;
            S_SHL_RD: begin
                n_state = i_sts.cur_next_lt_occ ? S_SHL_WR : S_RESP;
            end
            S_SHL_WR: n_state = S_SHL_RD;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.capture = i_in_valid;
            S_EVAL: begin
                o_cmd.eval      = 1'b1;
                o_cmd.wr_append = (i_sts.op == OP_APPEND);
                o_cmd.occ_inc   = (i_sts.op == OP_APPEND);
                o_cmd.rd_idx    = (i_sts.op == OP_READ);
            end
            S_SHR_RD: begin
                if (i_sts.cur_gt_tgt) begin
                    o_cmd.rd_prev = 1'b1;
                end else begin
                    o_cmd.wr_put  = 1'b1;
                    o_cmd.occ_inc = 1'b1;
                end
            end
            S_SHR_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.cur_dec  = 1'b1;
            end
            S_SHL_RD: begin
                if (i_sts.cur_next_lt_occ) begin
                    o_cmd.rd_next = 1'b1;
                end else begin
                    o_cmd.occ_dec = 1'b1;
                end
            end
            S_SHL_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.cur_inc  = 1'b1;
            end
            S_RESP: o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EVAL))
        else $error("accepted transaction did not move to evaluation");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr_append, o_cmd.wr_shift, o_cmd.wr_put}))
        else $error("more than one memory write in a cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.load_out)
        else $error("pending result overwritten");

endmodule

// ===== rtl/core/cssb_datapath.sv =====
// Datapath: request capture, bound checks, run tracking and the byte memory with its shifter.
`timescale 1ns / 1ps

module cssb_datapath
    import cssb_pkg::*;
#(
    parameter int DEPTH = CSSB_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [IDX_W-1:0] i_index,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_run_first,
    input  logic [LEN_W-1:0] i_run_length,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic [VAL_W-1:0] o_read_data,
    output logic [CNT_W-1:0] o_fill_count,
    output logic             o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > IDX_W) ? CW : IDX_W;
    localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;
    logic             r_first;
    logic [LEN_W-1:0] r_len;

    logic [CW-1:0]    r_occ;
    logic [PW-1:0]    r_run_pos;
    logic             r_run_acc;
    logic [LEN_W-1:0] r_run_left;

    t_op              r_op;
    logic [AW-1:0]    r_tgt;
    logic [AW-1:0]    r_cur;

    logic [PW-1:0]    occ_ext;
    logic [PW-1:0]    idx_ext;
    logic             room;
    logic             idx_ok;
    logic             eff_acc;
    logic [PW-1:0]    eff_pos;
    logic [LEN_W-1:0] eff_left;
    logic             ok_run;
    t_op              op_c;
    logic [AW-1:0]    tgt_c;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    assign occ_ext = PW'(r_occ);
    assign idx_ext = PW'(r_idx);
    assign room    = (r_occ < CW'(DEPTH));
    assign idx_ok  = (idx_ext < occ_ext);

    // A first run element re-opens the run; later elements carry on from the stored state.
    always_comb begin
        if (r_first) begin
            eff_acc  = idx_ok && (r_len != '0) &&
                       ((SW'(r_occ) + SW'(r_len)) <= SW'(DEPTH));
            eff_pos  = idx_ext;
            eff_left = eff_acc ? r_len : '0;
        end else begin
            eff_acc  = r_run_acc;
            eff_pos  = r_run_pos;
            eff_left = r_run_left;
        end
    end

    assign ok_run = eff_acc && (eff_left != '0) && room && (eff_pos < occ_ext);

    always_comb begin
        op_c  = OP_REJECT;
        tgt_c = AW'(r_idx);
        unique case (r_req)
            REQ_APPEND: if (room) op_c = OP_APPEND;
            REQ_INSERT: if (room && idx_ok) op_c = OP_SHIFT_IN;
            REQ_DELETE: if (idx_ok) op_c = OP_DELETE;
            REQ_READ:   if (idx_ok) op_c = OP_READ;
            REQ_RUN: begin
                tgt_c = AW'(eff_pos);
                if (ok_run) op_c = OP_SHIFT_IN;
            end
            default: op_c = OP_REJECT;
        endcase
    end

    assign o_sts.op              = op_c;
    assign o_sts.cur_gt_tgt      = (r_cur > r_tgt);
    assign o_sts.cur_next_lt_occ = ((SW'(r_cur) + SW'(1)) < SW'(r_occ));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_idx   <= i_index;
            r_val   <= i_value;
            r_first <= i_run_first;
            r_len   <= i_run_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_run_pos  <= '0;
            r_run_acc  <= 1'b0;
            r_run_left <= '0;
            r_op       <= OP_REJECT;
        end else begin
            if (i_cmd.occ_inc) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_cmd.occ_dec) begin
                r_occ <= r_occ - CW'(1);
            end
            if (i_cmd.eval) begin
                r_op <= op_c;
                if (r_req == REQ_RUN) begin
                    if (ok_run) begin
                        r_run_pos  <= eff_pos + PW'(1);
                        r_run_left <= eff_left - LEN_W'(1);
                        r_run_acc  <= (eff_left != LEN_W'(1));
                    end else begin
                        r_run_pos  <= eff_pos;
                        r_run_left <= eff_left;
                        r_run_acc  <= eff_acc && (eff_left != '0);
                    end
                end
            end
        end
    end

    // The cursor starts at the count for a right shift and at the index for a left shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_tgt <= tgt_c;
            r_cur <= (op_c == OP_DELETE) ? AW'(r_idx) : AW'(r_occ);
        end else if (i_cmd.cur_dec) begin
            r_cur <= r_cur - AW'(1);
        end else if (i_cmd.cur_inc) begin
            r_cur <= r_cur + AW'(1);
        end
    end

    always_comb begin
        mem_we    = i_cmd.wr_append || i_cmd.wr_shift || i_cmd.wr_put;
        mem_waddr = r_cur;
        mem_wdata = r_rdata;
        if (i_cmd.wr_append) begin
            mem_waddr = AW'(r_occ);
            mem_wdata = r_val;
        end else if (i_cmd.wr_put) begin
            mem_waddr = r_tgt;
            mem_wdata = r_val;
        end
    end

    always_comb begin
        mem_re    = i_cmd.rd_idx || i_cmd.rd_prev || i_cmd.rd_next;
        mem_raddr = AW'(r_idx);
        if (i_cmd.rd_prev) begin
            mem_raddr = r_cur - AW'(1);
        end else if (i_cmd.rd_next) begin
            mem_raddr = r_cur + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_read_data  <= (r_op == OP_READ) ? r_rdata : '0;
            o_fill_count <= CNT_W'(r_occ);
            o_status     <= (r_op == OP_REJECT);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy beyond capacity");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.occ_inc |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("occupancy did not step up by one");

    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_left != '0) |-> r_run_acc)
        else $error("run elements left without an accepted run");

endmodule

// ===== rtl/core/char_sequence_shift_buffer.sv =====
// Top level of the byte sequence shift buffer: controller and datapath.
`timescale 1ns / 1ps

// A byte sequence of up to DEPTH entries held in a single-port-write, registered-read
// memory, with append, insert, delete, read and run insert requests, each giving one
// result with the new count and a done or rejected status. One transaction is handled
// at a time. Append, read and any rejected request go from capture through evaluation
// straight to the result state, which loads the output register. An accepted insert,
// run element or delete first passes through a shift loop, because the tail moves
// one entry per read and write pair through the memory port, up for an insert and
// down for a delete. A result may wait in the output register while the next
// transaction is accepted; that next transaction then holds in its result state for
// as long as the result side stalls. The memory needs no clearing after reset.
module char_sequence_shift_buffer
    import cssb_pkg::*;
#(
    parameter int DEPTH = CSSB_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [IDX_W-1:0] i_index,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_run_first,
    input  logic [LEN_W-1:0] i_run_length,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAL_W-1:0] o_read_data,
    output logic [CNT_W-1:0] o_fill_count,
    output logic             o_status
);

    t_cmd cmd;
    t_sts sts;

    cssb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cssb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_run_first  (i_run_first),
        .i_run_length (i_run_length),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_read_data  (o_read_data),
        .o_fill_count (o_fill_count),
        .o_status     (o_status)
    );

endmodule

// ===== tb/sv/char_sequence_shift_buffer_tb.sv =====
// Self-checking testbench for the byte sequence shift buffer with a scoreboard class.
`timescale 1ns / 1ps

module char_sequence_shift_buffer_tb
    import cssb_pkg::*;
();

    localparam int DEPTH        = CSSB_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1650;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_FULL} t_phase;

    typedef struct {
        logic [VAL_W-1:0] read_data;
        logic [CNT_W-1:0] fill_count;
        logic             status;
    } t_seq_result;

    // Mirrors the sequence contents and count, and holds the results still owed by the block.
    class seq_mirror;
        localparam int DEPTH = CSSB_DEPTH_DEF;
        localparam logic ST_DONE     = 1'b0;
        localparam logic ST_REJECTED = 1'b1;

        logic [VAL_W-1:0] cells [DEPTH];
        int occupied;
        int run_pos;
        int run_left;
        bit run_open;

        t_seq_result owed [$];

        int failures;
        int checked;
        int rejected;
        int peak;
        int run_stored;

        function new();
            foreach (cells[i]) cells[i] = '0;
            occupied   = 0;
            run_pos    = 0;
            run_left   = 0;
            run_open   = 0;
            failures   = 0;
            checked    = 0;
            rejected   = 0;
            peak       = 0;
            run_stored = 0;
        endfunction

        function void shift_in(int pos, logic [VAL_W-1:0] b);
            for (int i = occupied; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = b;
            occupied++;
        endfunction

        // Applies one accepted transaction and queues the result it must produce.
        function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                   logic [VAL_W-1:0] val, logic first,
                                   logic [LEN_W-1:0] len);
            t_seq_result r;
            int pos;
            int n;
            pos = int'(idx);
            n   = int'(len);
            r.read_data = '0;
            r.status    = ST_REJECTED;
            case (req)
                REQ_APPEND: begin
                    if (occupied < DEPTH) begin
                        cells[occupied] = val;
                        occupied++;
                        r.status = ST_DONE;
                    end
                end
                REQ_INSERT: begin
                    if (occupied < DEPTH && pos < occupied) begin
                        shift_in(pos, val);
                        r.status = ST_DONE;
                    end
                end
                REQ_DELETE: begin
                    if (pos < occupied) begin
                        for (int i = pos; i + 1 < occupied; i++) cells[i] = cells[i+1];
                        occupied--;
                        r.status = ST_DONE;
                    end
                end
                REQ_READ: begin
                    if (pos < occupied) begin
                        r.read_data = cells[pos];
                        r.status    = ST_DONE;
                    end
                end
                REQ_RUN: begin
                    // Whether the run opens is judged on its first element.
                    if (first) begin
                        run_open = (pos < occupied) && (n != 0) &&
                                   (occupied + n <= DEPTH);
                        run_pos  = pos;
                        run_left = run_open ? n : 0;
                    end
                    if (run_open && run_left != 0 && occupied < DEPTH &&
                        run_pos < occupied) begin
                        shift_in(run_pos, val);
                        run_pos++;
                        run_left--;
                        run_stored++;
                        r.status = ST_DONE;
                    end
                    if (run_left == 0) run_open = 0;
                end
                default: ;
            endcase
            r.fill_count = occupied[CNT_W-1:0];
            if (occupied > peak) peak = occupied;
            owed = {owed, r};
        endfunction

        function void check_result(logic [VAL_W-1:0] rd, logic [CNT_W-1:0] cnt, logic st);
            t_seq_result e;
            if (owed.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%t: unexpected result rd=%02h cnt=%0d st=%0b, none pending",
                             $realtime, rd, cnt, st);
            end else begin
                e = owed.pop_front();
                checked++;
                if (st === ST_REJECTED) rejected++;
                if (rd !== e.read_data || cnt !== e.fill_count || st !== e.status) begin
                    failures++;
                    if (failures <= 10)
                        $display({"%t: result %0d mismatch: expected rd=%02h cnt=%0d ",
                                  "st=%0b, got rd=%02h cnt=%0d st=%0b"},
                                 $realtime, checked, e.read_data, e.fill_count,
                                 e.status, rd, cnt, st);
                end
            end
        endfunction
    endclass

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_stall;
    logic [REQ_W-1:0] i_req_type   = '0;
    logic [IDX_W-1:0] i_index      = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic             i_run_first  = 1'b0;
    logic [LEN_W-1:0] i_run_length = '0;
    logic             o_out_valid;
    logic             i_out_stall  = 1'b0;
    logic [VAL_W-1:0] o_read_data;
    logic [CNT_W-1:0] o_fill_count;
    logic             o_status;

    seq_mirror sb = new();

    int items_sent   = 0;
    bit in_quiet     = 0;
    bit out_quiet    = 0;
    int stall_left   = 0;
    int stretch_left = 0;

    char_sequence_shift_buffer #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_run_first  (i_run_first),
        .i_run_length (i_run_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_fill_count (o_fill_count),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Result side: stall bursts, mostly short, with quiet stretches in between.
    always @(negedge i_clk) begin
        if (stretch_left == 0) begin
            out_quiet    = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(50, 400);
        end else begin
            stretch_left--;
        end
        if (stall_left == 0 && !out_quiet && $urandom_range(0, 99) < 25)
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 3);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_read_data, o_fill_count, o_status);
    end

    // Presents one transaction, waits for it to be taken, then idles for a random gap.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, input logic first,
                                input logic [LEN_W-1:0] len);
        int gap;
        int r;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_index      <= idx;
        i_value      <= val;
        i_run_first  <= first;
        i_run_length <= len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req, idx, val, first, len);
        items_sent++;
        gap = 0;
        if (!in_quiet) begin
            r = $urandom_range(0, 99);
            if (r < 65)      gap = 0;
            else if (r < 88) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 12);
            else             gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if (sb.occupied > 0 && $urandom_range(0, 99) < 85)
            return IDX_W'($urandom_range(0, sb.occupied - 1));
        return IDX_W'($urandom_range(0, 127));
    endfunction

    task automatic send_plain(input t_phase ph);
        int r;
        logic [REQ_W-1:0] req;
        r = $urandom_range(0, 99);
        case (ph)
            PH_GROW: begin
                req = (r < 45) ? REQ_APPEND : (r < 75) ? REQ_INSERT :
                      (r < 85) ? REQ_DELETE : REQ_READ;
            end
            PH_SHRINK: begin
                req = (r < 10) ? REQ_APPEND : (r < 20) ? REQ_INSERT :
                      (r < 80) ? REQ_DELETE : REQ_READ;
            end
            PH_FULL: begin
                // Fill up first, then keep hammering the full store.
                if (sb.occupied < DEPTH)
                    req = REQ_APPEND;
                else
                    req = (r < 35) ? REQ_APPEND : (r < 65) ? REQ_INSERT :
                          (r < 85) ? REQ_READ : REQ_DELETE;
            end
            default: begin
                req = (r < 25) ? REQ_APPEND : (r < 50) ? REQ_INSERT :
                      (r < 75) ? REQ_DELETE : REQ_READ;
            end
        endcase
        send_request(req, pick_index(), VAL_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        send_request(REQ_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 127)),
                     VAL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     LEN_W'($urandom_range(0, 255)));
    endtask

    task automatic send_run(input t_phase ph);
        int cnt;
        int room;
        int start;
        int len;
        int r;
        cnt  = sb.occupied;
        room = DEPTH - cnt;
        r    = $urandom_range(0, 99);
        if (cnt == 0 || room == 0 || r < 10) begin
            // A run that must be turned away on its first element.
            r = $urandom_range(0, 2);
            if (r == 0 && cnt < DEPTH) begin
                start = $urandom_range(cnt, 127);
                len   = $urandom_range(1, 8);
            end else if (r == 1) begin
                start = pick_index();
                len   = 0;
            end else begin
                start = pick_index();
                len   = $urandom_range(room + 1, 255);
            end
            send_request(REQ_RUN, IDX_W'(start), VAL_W'($urandom_range(0, 255)), 1'b1,
                         LEN_W'(len));
            repeat ($urandom_range(1, 3))
                send_request(REQ_RUN, IDX_W'($urandom_range(0, 127)),
                             VAL_W'($urandom_range(0, 255)), 1'b0,
                             LEN_W'($urandom_range(0, 255)));
        end else begin
            start = $urandom_range(0, cnt - 1);
            r     = $urandom_range(0, 99);
            if (r < 80)      len = $urandom_range(1, (room < 8) ? room : 8);
            else if (r < 95) len = $urandom_range(1, room);
            else             len = room;
            send_request(REQ_RUN, IDX_W'(start), VAL_W'($urandom_range(0, 255)), 1'b1,
                         LEN_W'(len));
            for (int k = 1; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 4) break;
                if (r < 16) send_plain(ph);
                send_request(REQ_RUN, IDX_W'($urandom_range(0, 127)),
                             VAL_W'($urandom_range(0, 255)), 1'b0,
                             LEN_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 8)
                send_request(REQ_RUN, IDX_W'($urandom_range(0, 127)),
                             VAL_W'($urandom_range(0, 255)), 1'b0,
                             LEN_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        #30_000_000;
        $display("%t: timeout with %0d results outstanding", $realtime, sb.owed.size());
        $display("char_sequence_shift_buffer verification failed");
        $finish;
    end

    initial begin
        int target;
        int r;
        int ph_len;
        t_phase ph;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: everything that needs an occupied position is rejected.
        send_request(REQ_READ,   7'd0,   8'h00, 1'b0, 8'd0);
        send_request(REQ_DELETE, 7'd0,   8'h00, 1'b0, 8'd0);
        send_request(REQ_INSERT, 7'd0,   8'h11, 1'b0, 8'd0);
        send_request(REQ_RUN,    7'd0,   8'h22, 1'b1, 8'd1);
        for (int c = REQ_RUN + 1; c < 8; c++)
            send_request(REQ_W'(c), 7'd127, 8'hFF, 1'b1, 8'hFF);
        // The run marker on an append is ignored.
        send_request(REQ_APPEND, 7'd127, 8'h00, 1'b1, 8'hFF);
        send_request(REQ_APPEND, 7'd0,   8'hFF, 1'b0, 8'd0);
        send_request(REQ_APPEND, 7'd0,   8'hA5, 1'b0, 8'd0);
        send_request(REQ_INSERT, 7'd0,   8'h5A, 1'b0, 8'd0);
        send_request(REQ_INSERT, 7'd4,   8'h33, 1'b0, 8'd0);
        send_request(REQ_READ,   7'd127, 8'h00, 1'b0, 8'd0);
        send_request(REQ_READ,   7'd3,   8'h00, 1'b0, 8'd0);
        // A two element run, then one element too many.
        send_request(REQ_RUN,    7'd1,   8'h81, 1'b1, 8'd2);
        send_request(REQ_RUN,    7'd0,   8'h7E, 1'b0, 8'd0);
        send_request(REQ_RUN,    7'd0,   8'h44, 1'b0, 8'd0);
        // Zero length and oversized runs are refused together with what follows.
        send_request(REQ_RUN,    7'd0,   8'h55, 1'b1, 8'd0);
        send_request(REQ_RUN,    7'd0,   8'h66, 1'b1, 8'd128);
        send_request(REQ_RUN,    7'd0,   8'h77, 1'b0, 8'd0);
        send_request(REQ_DELETE, 7'd5,   8'h00, 1'b0, 8'd0);
        send_request(REQ_DELETE, 7'd0,   8'h00, 1'b0, 8'd0);
        send_request(REQ_READ,   7'd0,   8'h00, 1'b0, 8'd0);
        send_request(REQ_READ,   7'd4,   8'h00, 1'b0, 8'd0);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            r = $urandom_range(0, 9);
            ph = (r == 0) ? PH_FULL : (r < 4) ? PH_GROW : (r < 7) ? PH_SHRINK : PH_MIXED;
            ph_len   = (ph == PH_FULL) ? 160 : $urandom_range(15, 60);
            in_quiet = ($urandom_range(0, 4) == 0);
            for (int s = 0; s < ph_len && items_sent < target; s++) begin
                r = $urandom_range(0, 99);
                if (r < 6)       send_noise();
                else if (r < 24) send_run(ph);
                else             send_plain(ph);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        // Longest shift through a full store, with margin for any stray result.
        repeat (300) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results, %0d of them rejected.",
                 items_sent, sb.checked, sb.rejected);
        $display("Fill peaked at %0d of %0d cells; %0d run elements were stored.",
                 sb.peak, DEPTH, sb.run_stored);
        if (sb.failures == 0 && sb.owed.size() == 0) begin
            $display("char_sequence_shift_buffer verification clean");
        end else begin
            $display("%0d failures, %0d results outstanding", sb.failures, sb.owed.size());
            $display("char_sequence_shift_buffer verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cssb_pkg.sv
rtl/core/cssb_ctrl.sv
rtl/core/cssb_datapath.sv
rtl/core/char_sequence_shift_buffer.sv
tb/sv/char_sequence_shift_buffer_tb.sv
